[hdl/itsp_pkg.sv]
// Shared types and constants for the temperature-sensor poller.
// Holds the phase encoding, bus command and status codes, and the result beat.
// No dependencies.
package itsp_pkg;

  // One-hot sequencing phases of a sensor read.
  typedef enum logic [8:0] {
    PH_IDLE       = 9'b000000001,
    PH_START_DONE = 9'b000000010,
    PH_ADDRW_DONE = 9'b000000100,
    PH_PTR_DONE   = 9'b000001000,
    PH_RSTRT_DONE = 9'b000010000,
    PH_ADDRR_DONE = 9'b000100000,
    PH_HIGH_DONE  = 9'b001000000,
    PH_LOW_DONE   = 9'b010000000,
    PH_ERROR      = 9'b100000000
  } itsp_phase_t;

  // Bus commands issued to the I2C master.
  localparam logic [2:0] CMD_NONE  = 3'd0;
  localparam logic [2:0] CMD_START = 3'd1;
  localparam logic [2:0] CMD_SEND  = 3'd2;
  localparam logic [2:0] CMD_READ  = 3'd3;
  localparam logic [2:0] CMD_STOP  = 3'd4;

  // Status codes reported by the master; only the upper five bits count.
  localparam logic [7:0] ST_MASK     = 8'hF8;
  localparam logic [7:0] ST_START    = 8'h08;
  localparam logic [7:0] ST_RESTART  = 8'h10;
  localparam logic [7:0] ST_ADDR_W   = 8'h18;
  localparam logic [7:0] ST_DATA_ACK = 8'h28;
  localparam logic [7:0] ST_ADDR_R   = 8'h40;
  localparam logic [7:0] ST_DATA_NAK = 8'h58;

  // Pointer register selected before reading the temperature.
  localparam logic [7:0] TEMP_POINTER = 8'h00;

  // Largest in-range code; a sum reaching it saturates and is flagged invalid.
  localparam logic [7:0] TEMP_SAT = 8'd255;

  // Configuration register indexes.
  localparam logic CFG_DEVICE_ADDRESS = 1'b0;
  localparam logic CFG_TEMP_OFFSET    = 1'b1;

  // One result beat.
  typedef struct packed {
    logic [2:0] bus_command;
    logic [7:0] tx_byte;
    logic [7:0] temp_code;
    logic       temp_valid;
    logic       bus_error;
  } itsp_result_t;

endpackage

[hdl/i2c_temp_sensor_poller_core.sv]
// Top level of the temperature-sensor poller.
// Holds the phase and configuration registers and the output register.
// Depends on itsp_pkg and itsp_step.

// Each input beat reports the completion of the previous I2C bus operation
// (masked status and received byte); the block answers with exactly one result
// beat naming the next operation, in the order start, address+write, pointer
// byte, repeated start, address+read, read high, read low, stop. A status other
// than the one expected for the phase reports bus_error, issues no operation,
// and the next beat issues a stop. The step that completes the low read carries
// the offset temperature in half degrees, clamped to 0..255, with temp_valid
// low when it saturates at 255. The block takes one beat per clock cycle and
// each result appears in the cycle after its input beat, held in a single output
// register; the input stalls only while that register is full and the output
// side stalls. Configuration writes take effect on the next beat and are
// meant to be done while the block is idle.
module i2c_temp_sensor_poller_core import itsp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,

  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_bus_status,
  input  logic [7:0] in_rx_byte,

  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_bus_command,
  output logic [7:0] out_tx_byte,
  output logic [7:0] out_temp_code,
  output logic       out_temp_valid,
  output logic       out_bus_error,

  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_wdata
);

  itsp_phase_t  phase_r;
  itsp_phase_t  phase_nxt;
  logic [7:0]   high_byte_r;
  logic [7:0]   high_byte_nxt;
  logic [6:0]   device_address_r;
  logic [7:0]   temp_offset_r;
  itsp_result_t result_nxt;
  itsp_result_t result_r;
  logic         out_valid_r;
  logic         in_accept;

  // The output register can take a new beat whenever it is empty or drains
  // in this same cycle.
  assign in_stall  = out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;

  itsp_step u_step (
    .phase          (phase_r),
    .high_byte      (high_byte_r),
    .bus_status     (in_bus_status),
    .rx_byte        (in_rx_byte),
    .device_address (device_address_r),
    .temp_offset    (temp_offset_r),
    .phase_nxt      (phase_nxt),
    .high_byte_nxt  (high_byte_nxt),
    .result         (result_nxt)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      device_address_r <= 7'd72;
      temp_offset_r    <= 8'd64;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEVICE_ADDRESS: device_address_r <= cfg_wdata[6:0];
        CFG_TEMP_OFFSET:    temp_offset_r    <= cfg_wdata;
        default:            temp_offset_r    <= temp_offset_r;
      endcase
    end
  end

  // Sequencer state advances once per accepted beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      high_byte_r <= 8'd0;
    end else if (in_accept) begin
      phase_r     <= phase_nxt;
      high_byte_r <= high_byte_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      result_r <= result_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_bus_command = result_r.bus_command;
  assign out_tx_byte     = result_r.tx_byte;
  assign out_temp_code   = result_r.temp_code;
  assign out_temp_valid  = result_r.temp_valid;
  assign out_bus_error   = result_r.bus_error;

endmodule

[hdl/itsp_step.sv]
// Combinational next-step logic of the temperature-sensor poller.
// Checks the completed operation's status, picks the next bus command and
// converts the reading. Depends on itsp_pkg.
module itsp_step import itsp_pkg::*; (
  input  itsp_phase_t  phase,
  input  logic [7:0]   high_byte,
  input  logic [7:0]   bus_status,
  input  logic [7:0]   rx_byte,
  input  logic [6:0]   device_address,
  input  logic [7:0]   temp_offset,
  output itsp_phase_t  phase_nxt,
  output logic [7:0]   high_byte_nxt,
  output itsp_result_t result
);

  logic [7:0]        addr_w;
  logic [7:0]        addr_r;
  logic [7:0]        expect_st;
  logic              check;
  logic [2:0]        cmd;
  logic [7:0]        tx;
  itsp_phase_t       seq_nxt;
  logic signed [9:0] sum;
  logic [7:0]        code;
  logic              valid;

  assign addr_w = {device_address, 1'b0};
  assign addr_r = {device_address, 1'b1};

  // The reading is bits 15..7 of the two bytes: a 9-bit two's complement value
  // in half degrees. The offset is unsigned.
  assign sum = $signed({high_byte[7], high_byte, rx_byte[7]}) +
               $signed({2'b00, temp_offset});

  always_comb begin
    if (sum < 0) begin
      code  = 8'd0;
      valid = 1'b1;
    end else if (sum >= $signed({2'b00, TEMP_SAT})) begin
      code  = TEMP_SAT;
      valid = 1'b0;
    end else begin
      code  = sum[7:0];
      valid = 1'b1;
    end
  end

  always_comb begin
    expect_st     = 8'd0;
    check         = 1'b1;
    cmd           = CMD_STOP;
    tx            = 8'd0;
    seq_nxt       = PH_IDLE;
    high_byte_nxt = high_byte;
    unique case (phase)
      PH_IDLE: begin
        check   = 1'b0;
        cmd     = CMD_START;
        seq_nxt = PH_START_DONE;
      end
      PH_START_DONE: begin
        expect_st = ST_START;
        cmd       = CMD_SEND;
        tx        = addr_w;
        seq_nxt   = PH_ADDRW_DONE;
      end
      PH_ADDRW_DONE: begin
        expect_st = ST_ADDR_W;
        cmd       = CMD_SEND;
        tx        = TEMP_POINTER;
        seq_nxt   = PH_PTR_DONE;
      end
      PH_PTR_DONE: begin
        expect_st = ST_DATA_ACK;
        cmd       = CMD_START;
        seq_nxt   = PH_RSTRT_DONE;
      end
      PH_RSTRT_DONE: begin
        expect_st = ST_RESTART;
        cmd       = CMD_SEND;
        tx        = addr_r;
        seq_nxt   = PH_ADDRR_DONE;
      end
      PH_ADDRR_DONE: begin
        expect_st = ST_ADDR_R;
        cmd       = CMD_READ;
        seq_nxt   = PH_HIGH_DONE;
      end
      PH_HIGH_DONE: begin
        // The high byte is kept even if the status turns out wrong.
        high_byte_nxt = rx_byte;
        expect_st     = ST_DATA_NAK;
        cmd           = CMD_READ;
        seq_nxt       = PH_LOW_DONE;
      end
      PH_LOW_DONE: begin
        check = 1'b0;
      end
      default: begin
        // Error phase and any stray encoding: stop and return to idle.
        check = 1'b0;
      end
    endcase
  end

  always_comb begin
    result = '0;
    if (check && ((bus_status & ST_MASK) != expect_st)) begin
      result.bus_command = CMD_NONE;
      result.bus_error   = 1'b1;
      phase_nxt          = PH_ERROR;
    end else begin
      result.bus_command = cmd;
      result.tx_byte     = tx;
      phase_nxt          = seq_nxt;
      if (phase == PH_LOW_DONE) begin
        result.temp_code  = code;
        result.temp_valid = valid;
      end
    end
  end

endmodule
